[rtl/swm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window mean
// constants, defaults and the command / status groups between
// the controller and the datapath
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int TAG_W            = 32;
    localparam int CFG_W            = 11;
    localparam int WINDOW_MAX_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int WINDOW_RESET     = 10;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic load_out;
    } swm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } swm_sts_t;

endpackage

[rtl/sliding_window_mean.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean: moving average filter over a sample ring
// per sample: drop the oldest value once the window is full, add the new
// one, emit the tag with sum / fill count truncated toward zero
// ----------------------------------------------------------------------------
//
//  channel   signals                                  dir   transfer when
//  --------  ---------------------------------------  ----  -------------------
//  input     in_valid, in_stall, sample_tag,           in    in_valid & !in_stall
//            sample_value
//  output    out_valid, out_stall, result_tag,         out   out_valid & !out_stall
//            window_mean
//  config    cfg_write_en, cfg_write_data              in    cfg_write_en
//
//  one sample at a time, stepped through capture, sum update, divider start,
//  division and result load; SUM_W = SAMPLE_WIDTH + log2(WINDOW_MAX), 42 at
//  the defaults, is the dividend width of the radix-2 divider, which produces
//  one quotient bit per cycle; the result waits in an output register, so
//  the next sample transfer can be taken while out_stall holds the previous
//  result
//  reset gives window size 10 (or WINDOW_MAX if smaller) and an empty window;
//  the ring itself is not cleared, entries are read only after being written
//  a window size write restarts sum, fill count and position; zero is taken
//  as one and values above WINDOW_MAX saturate
// ----------------------------------------------------------------------------
module sliding_window_mean
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_write_en,
    input  logic [CFG_W-1:0]               cfg_write_data,
    // sample input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [TAG_W-1:0]               sample_tag,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [TAG_W-1:0]               result_tag,
    output logic signed [SAMPLE_WIDTH-1:0] window_mean
);

    swm_cmd_t cmd;   // sequencing commands
    swm_sts_t sts;   // divider and output register status

    // state machine: capture, update, divide, load result
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ring, running sum, divider and output register
    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .sample_tag     (sample_tag),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_tag     (result_tag),
        .window_mean    (window_mean)
    );

endmodule

[rtl/swm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_div: radix-2 restoring divider
// signed dividend by positive divisor, one quotient bit per cycle,
// quotient truncated toward zero
// ----------------------------------------------------------------------------
module swm_div #(
    parameter int SUM_W = 42,
    parameter int DIV_W = 11,
    parameter int Q_W   = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [DIV_W-1:0] divisor,
    output logic                    done,
    output logic signed [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] quot_reg;
    logic [DIV_W-1:0] rem_reg;

    logic [SUM_W-1:0] mag;
    logic [DIV_W:0]   rem_shift;
    logic             ge;
    logic [DIV_W:0]   rem_diff;
    logic [SUM_W-1:0] quot_signed;

    // magnitude of the dividend, most negative value included
    assign mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign ge        = (rem_shift >= {1'b0, divisor});
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            quot_reg <= mag;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], ge};
            rem_reg  <= ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        end
    end

    assign quot_signed = neg_reg ? (~quot_reg + SUM_W'(1)) : quot_reg;
    assign quotient    = quot_signed[Q_W-1:0];
    assign done        = done_reg;

endmodule

[rtl/swm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_datapath: window ring, running sum and output register
// holds the sample ring, fill count, write position, window size,
// the divider and the result register
// ----------------------------------------------------------------------------
module swm_datapath
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_cmd_t                       cmd,
    output swm_sts_t                       sts,
    input  logic                           cfg_write_en,
    input  logic [CFG_W-1:0]               cfg_write_data,
    input  logic [TAG_W-1:0]               sample_tag,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [TAG_W-1:0]               result_tag,
    output logic signed [SAMPLE_WIDTH-1:0] window_mean
);

    localparam int ADDR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int COUNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = SAMPLE_WIDTH + ADDR_W;
    localparam int RESET_SIZE = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

    logic signed [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];

    logic [COUNT_W-1:0]             wsize_reg;
    logic [COUNT_W-1:0]             fill_reg;
    logic [ADDR_W-1:0]              pos_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic                           out_valid_reg;

    logic [ADDR_W-1:0]              slot_reg;
    logic [TAG_W-1:0]               tag_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic [TAG_W-1:0]               result_tag_reg;
    logic signed [SAMPLE_WIDTH-1:0] mean_reg;

    logic [ADDR_W-1:0]              slot_next;
    logic [COUNT_W-1:0]             slot_inc;
    logic [ADDR_W-1:0]              pos_next;
    logic                           full;
    logic signed [SUM_W-1:0]        drop;
    logic signed [SUM_W-1:0]        sum_next;
    logic [31:0]                    cfg_wide;
    logic [COUNT_W-1:0]             cfg_size;
    logic                           div_done;
    logic signed [SAMPLE_WIDTH-1:0] quotient;

    // a position past the current window wraps to the first slot
    assign slot_next = (COUNT_W'(pos_reg) >= wsize_reg) ? '0 : pos_reg;
    assign slot_inc  = COUNT_W'(slot_reg) + COUNT_W'(1);
    assign pos_next  = (slot_inc >= wsize_reg) ? '0 : slot_inc[ADDR_W-1:0];

    assign full     = (fill_reg >= wsize_reg);
    assign drop     = full ? SUM_W'(old_reg) : '0;
    assign sum_next = sum_reg - drop + SUM_W'(value_reg);

    // zero reads as one, oversize saturates
    assign cfg_wide = 32'(cfg_write_data);
    always_comb
    begin
        if (cfg_wide == 32'd0)
            cfg_size = COUNT_W'(1);
        else if (cfg_wide > 32'(WINDOW_MAX))
            cfg_size = COUNT_W'(WINDOW_MAX);
        else
            cfg_size = cfg_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg     <= COUNT_W'(RESET_SIZE);
            fill_reg      <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                wsize_reg <= cfg_size;
                fill_reg  <= '0;
                pos_reg   <= '0;
                sum_reg   <= '0;
            end
            else if (cmd.update)
            begin
                if (!full)
                    fill_reg <= fill_reg + COUNT_W'(1);
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // sample ring, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            old_reg <= ring_mem[slot_next];
        if (cmd.update)
            ring_mem[slot_reg] <= value_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg  <= slot_next;
            tag_reg   <= sample_tag;
            value_reg <= sample_value;
        end
        if (cmd.load_out)
        begin
            result_tag_reg <= tag_reg;
            mean_reg       <= quotient;
        end
    end

    swm_div #(
        .SUM_W (SUM_W),
        .DIV_W (COUNT_W),
        .Q_W   (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign result_tag  = result_tag_reg;
    assign window_mean = mean_reg;

endmodule

[rtl/swm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl: sequencing state machine
// steps one sample through capture, sum update, division and output
// ----------------------------------------------------------------------------
module swm_ctrl
    import swm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  swm_sts_t sts,
    output swm_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule
